FILE: sv/lpms_pkg.sv
package lpms_pkg;

   localparam int REG_W          = 16;
   localparam int TIME_BITS_DEF  = 16;
   localparam int CSR_IDX_W      = 2;

   localparam logic [REG_W-1:0] PULSE_LENGTH_RST  = 16'd100;
   localparam logic [REG_W-1:0] PULSE_PERIOD_RST  = 16'd1000;
   localparam logic [REG_W-1:0] STROBE_LENGTH_RST = 16'd200;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSE_LENGTH  = 2'd0,
      CSR_PULSE_PERIOD  = 2'd1,
      CSR_STROBE_LENGTH = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      MODE_OFF          = 3'd0,
      MODE_FLASH_YELLOW = 3'd1,
      MODE_GREEN        = 3'd2,
      MODE_BLUE         = 3'd3,
      MODE_STROBE       = 3'd4,
      MODE_FLASH        = 3'd5
   } mode_type;

endpackage

FILE: sv/lpms_if.sv
interface lpms_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [2:0] new_mode;

   modport source (output valid, output kind, output new_mode, input ready);
   modport sink   (input valid, input kind, input new_mode, output ready);
endinterface

interface lpms_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] led_drive;
   logic       drive_changed;
   logic       strobing;

   modport source (output valid, output led_drive, output drive_changed,
                   output strobing, input ready);
   modport sink   (input valid, input led_drive, input drive_changed,
                   input strobing, output ready);
endinterface

FILE: sv/led_pulse_mode_sequencer_core.sv
// A word accepted at one clock edge shows its result word on rsp_ch, held in the
// result register, right after that edge.
// Throughput: one word per cycle; the result register frees itself in the same
// cycle it is taken, so req_ch stalls only while rsp_ch is stalled.
// Reset (synchronous, active high): mode and saved mode off, elapsed count and
// lit flag cleared, registers back to 100 / 1000 / 200 ms, result word dropped.
module led_pulse_mode_sequencer_core
   import lpms_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   lpms_req_if.sink             req_ch,
   lpms_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   localparam int CMP_W = (TIME_BITS > REG_W) ? TIME_BITS : REG_W;
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   logic [REG_W-1:0]     pulse_length_ff, pulse_period_ff, strobe_length_ff;
   mode_type             mode_ff, mode_in;
   mode_type             saved_mode_ff, saved_mode_in;
   mode_type             drive_ff, drive_in;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in;
   logic                 lit_ff, lit_in;
   logic                 changed;

   logic                 rsp_valid_ff;
   logic [2:0]           rsp_drive_ff;
   logic                 rsp_changed_ff, rsp_strobing_ff;

   logic                 accept;
   logic [TIME_BITS-1:0] elapsed_inc;
   logic [CMP_W-1:0]     elapsed_ext, length_ext, period_ext, strobe_ext;
   logic                 length_hit, period_hit, strobe_hit;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign elapsed_inc = (elapsed_ff == TIME_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
   assign elapsed_ext = CMP_W'(elapsed_inc);
   assign length_ext  = CMP_W'(pulse_length_ff);
   assign period_ext  = CMP_W'(pulse_period_ff);
   assign strobe_ext  = CMP_W'(strobe_length_ff);
   assign length_hit  = elapsed_ext >= length_ext;
   assign period_hit  = elapsed_ext >= period_ext;
   assign strobe_hit  = elapsed_ext >= strobe_ext;

   always_comb begin
      mode_in       = mode_ff;
      saved_mode_in = saved_mode_ff;
      drive_in      = drive_ff;
      elapsed_in    = elapsed_ff;
      lit_in        = lit_ff;
      changed       = 1'b0;
      if (req_ch.kind) begin
         // ignore undefined mode codes
         if (req_ch.new_mode <= MODE_FLASH) begin
            if (mode_type'(req_ch.new_mode) == MODE_STROBE && mode_ff != MODE_STROBE) begin
               saved_mode_in = mode_ff;
            end
            mode_in    = mode_type'(req_ch.new_mode);
            drive_in   = mode_type'(req_ch.new_mode);
            elapsed_in = '0;
            lit_in     = mode_type'(req_ch.new_mode) != MODE_OFF &&
                         mode_type'(req_ch.new_mode) != MODE_STROBE;
            changed    = 1'b1;
         end
      end else begin
         elapsed_in = elapsed_inc;
         case (mode_ff)
            MODE_FLASH_YELLOW, MODE_FLASH: begin
               if (lit_ff && length_hit) begin
                  drive_in = MODE_OFF;
                  lit_in   = 1'b0;
                  changed  = 1'b1;
               end else if (!lit_ff && period_hit) begin
                  drive_in   = mode_ff;
                  lit_in     = 1'b1;
                  elapsed_in = '0;
                  changed    = 1'b1;
               end
            end
            MODE_GREEN, MODE_BLUE: begin
               if (lit_ff && length_hit) begin
                  drive_in = MODE_OFF;
                  lit_in   = 1'b0;
                  changed  = 1'b1;
               end
            end
            MODE_STROBE: begin
               // restore the earlier mode as if freshly commanded
               if (strobe_hit) begin
                  mode_in    = saved_mode_ff;
                  drive_in   = saved_mode_ff;
                  elapsed_in = '0;
                  lit_in     = saved_mode_ff != MODE_OFF;
                  changed    = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_length_ff  <= PULSE_LENGTH_RST;
         pulse_period_ff  <= PULSE_PERIOD_RST;
         strobe_length_ff <= STROBE_LENGTH_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PULSE_LENGTH:  pulse_length_ff  <= csr_wdata;
            CSR_PULSE_PERIOD:  pulse_period_ff  <= csr_wdata;
            CSR_STROBE_LENGTH: strobe_length_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_OFF;
         saved_mode_ff <= MODE_OFF;
         drive_ff      <= MODE_OFF;
         elapsed_ff    <= '0;
         lit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff       <= mode_in;
            saved_mode_ff <= saved_mode_in;
            drive_ff      <= drive_in;
            elapsed_ff    <= elapsed_in;
            lit_ff        <= lit_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result word payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_drive_ff    <= drive_in;
         rsp_changed_ff  <= changed;
         rsp_strobing_ff <= mode_in == MODE_STROBE;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.led_drive     = rsp_drive_ff;
   assign rsp_ch.drive_changed = rsp_changed_ff;
   assign rsp_ch.strobing      = rsp_strobing_ff;

   a_saved_not_strobe: assert property (@(posedge clock) disable iff (reset)
      saved_mode_ff != MODE_STROBE)
      else $error("saved mode holds strobe");

   a_lit_drive: assert property (@(posedge clock) disable iff (reset)
      lit_ff |-> drive_ff == mode_ff)
      else $error("lit but drive differs from mode");

   a_strobe_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_strobing_ff |-> rsp_drive_ff == MODE_STROBE)
      else $error("strobing word without strobe pattern");

   a_cmd_changed: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.kind && req_ch.new_mode <= MODE_FLASH
      |=> rsp_valid_ff && rsp_changed_ff)
      else $error("valid command did not flag a change");

endmodule
